// ===== src/potb_pkg.sv =====
// shared types, constants and helpers for the pending operation timer bank
// no dependencies; used by every module of the block by scoped name
package potb_pkg;

   // slot bank geometry
   localparam int SLOTS     = 8;
   localparam int SLOT_W    = $clog2(SLOTS);
   localparam int OP_W      = 2;
   localparam int MASK_W    = 8;
   localparam int DELAY_W   = 16;

   // opcode bits that map to a real slot
   localparam logic [MASK_W-1:0] USABLE_MASK =
      (SLOTS >= MASK_W) ? {MASK_W{1'b1}} : MASK_W'((1 << SLOTS) - 1);

   // a counter holding this value fires on the next tick
   localparam logic [DELAY_W-1:0] COUNT_LAST = DELAY_W'(1);

   // request operation codes
   localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
   localparam logic [OP_W-1:0] OP_CANCEL = 2'd1;
   localparam logic [OP_W-1:0] OP_TICK   = 2'd2;

   // controller to datapath commands
   typedef struct packed {
      logic capture;   // latch the incoming request
      logic apply;     // update slot state from the latched request
      logic load_rsp;  // load the response payload registers
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic is_tick;   // latched request is a tick
   } status_type;

   // position of the highest set bit, zero for an empty mask
   function automatic logic [SLOT_W-1:0] top_bit(input logic [MASK_W-1:0] mask);
      logic [SLOT_W-1:0] pos;
      pos = '0;
      for (int i = 0; i < SLOTS; i++) begin
         if (mask[i]) begin
            pos = SLOT_W'(i);
         end
      end
      return pos;
   endfunction

endpackage

// ===== src/potb_ctrl.sv =====
// controller state machine for the pending operation timer bank
// depends on potb_pkg for the command and status structs
module potb_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  potb_pkg::status_type  status,
   output potb_pkg::cmd_type     cmd
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      hold;

   // a tick waits in exec while an older response is still stalled
   assign hold = status.is_tick && rsp_valid_ff && rsp_stall;

   // command decode
   always_comb begin
      cmd.capture  = (state_ff == ST_IDLE) && req_valid;
      cmd.apply    = (state_ff == ST_EXEC) && !hold;
      cmd.load_rsp = cmd.apply && status.is_tick;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (!hold) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // response valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== src/potb_dp.sv =====
// datapath for the pending operation timer bank: request latch, pending mask,
// slot countdowns and response payload; depends on potb_pkg
module potb_dp (
   input  logic                            clock,
   input  logic                            reset,
   input  potb_pkg::cmd_type               cmd,
   output potb_pkg::status_type            status,
   input  logic [potb_pkg::OP_W-1:0]       req_op,
   input  logic [potb_pkg::MASK_W-1:0]     req_opcode,
   input  logic [potb_pkg::DELAY_W-1:0]    req_delay_ms,
   output logic [potb_pkg::MASK_W-1:0]     rsp_fired_mask,
   output logic [potb_pkg::MASK_W-1:0]     rsp_pending_after
);

   logic [potb_pkg::OP_W-1:0]    op_ff;
   logic [potb_pkg::MASK_W-1:0]  code_ff;
   logic [potb_pkg::DELAY_W-1:0] delay_ff;

   logic [potb_pkg::MASK_W-1:0]  pending_ff, pending_in;
   logic [potb_pkg::DELAY_W-1:0] count_ff [potb_pkg::SLOTS];
   logic [potb_pkg::DELAY_W-1:0] count_in [potb_pkg::SLOTS];

   logic [potb_pkg::MASK_W-1:0]  fired_ff, fired_in;
   logic [potb_pkg::MASK_W-1:0]  after_ff;

   logic [potb_pkg::SLOT_W-1:0]  top;
   logic                         code_nz;
   logic                         add_ok;

   // request latch, unusable opcode bits dropped here
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_op;
         code_ff  <= req_opcode & potb_pkg::USABLE_MASK;
         delay_ff <= req_delay_ms;
      end
   end

   assign status.is_tick = (op_ff == potb_pkg::OP_TICK);

   // decode of the latched request
   assign top     = potb_pkg::top_bit(code_ff);
   assign code_nz = (code_ff != '0);
   assign add_ok  = code_nz && ((pending_ff & code_ff) == '0);

   // slots that reach zero on a tick
   always_comb begin
      fired_in = '0;
      for (int i = 0; i < potb_pkg::SLOTS; i++) begin
         fired_in[i] = (count_ff[i] == potb_pkg::COUNT_LAST);
      end
   end

   // next slot counters, one lane per slot
   always_comb begin
      for (int i = 0; i < potb_pkg::SLOTS; i++) begin
         count_in[i] = count_ff[i];
         case (op_ff)
            potb_pkg::OP_ADD: begin
               if (add_ok && top == potb_pkg::SLOT_W'(i)) count_in[i] = delay_ff;
            end
            potb_pkg::OP_CANCEL: begin
               if (code_nz && top == potb_pkg::SLOT_W'(i)) count_in[i] = '0;
            end
            potb_pkg::OP_TICK: begin
               if (count_ff[i] != '0) count_in[i] = count_ff[i] - potb_pkg::COUNT_LAST;
            end
            default: count_in[i] = count_ff[i];
         endcase
      end
   end

   // next pending mask
   always_comb begin
      pending_in = pending_ff;
      case (op_ff)
         potb_pkg::OP_ADD: begin
            if (add_ok) pending_in = pending_ff | code_ff;
         end
         potb_pkg::OP_CANCEL: pending_in = pending_ff & ~code_ff;
         potb_pkg::OP_TICK:   pending_in = pending_ff & ~fired_in;
         default:             pending_in = pending_ff;
      endcase
   end

   // slot state
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         for (int i = 0; i < potb_pkg::SLOTS; i++) begin
            count_ff[i] <= '0;
         end
      end else if (cmd.apply) begin
         pending_ff <= pending_in;
         for (int i = 0; i < potb_pkg::SLOTS; i++) begin
            count_ff[i] <= count_in[i];
         end
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         fired_ff <= fired_in;
         after_ff <= pending_in;
      end
   end

   assign rsp_fired_mask    = fired_ff;
   assign rsp_pending_after = after_ff;

endmodule

// ===== src/pending_op_timer_bank.sv =====
// pending operation timer bank: eight delayed-operation slots
// each with a 16-bit countdown and a pending bit.
// request channel (req_valid / req_stall): req_op selects add, cancel
// or a one millisecond tick; req_opcode is the operation mask and
// req_delay_ms the countdown loaded by an add.
// response channel (rsp_valid / rsp_stall): one response per tick,
// carrying rsp_fired_mask and rsp_pending_after; add, cancel and the
// unused op code give no response.
// a tick's response is registered: the controller captures the request,
// then its apply step loads the response registers, and a hold can come
// between the two. a new request is taken only after the capture then
// apply sequence of the controller is through with the last one.
// a request is taken while an older response still waits; a tick then
// holds in the apply step until the response register frees up, so a
// stalled receiver stops the request side after one more tick.
// reset (synchronous, active high) clears the pending mask, all slot
// counters and the response valid flag.
// depends on potb_pkg, potb_ctrl and potb_dp
module pending_op_timer_bank (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [potb_pkg::OP_W-1:0]       req_op,
   input  logic [potb_pkg::MASK_W-1:0]     req_opcode,
   input  logic [potb_pkg::DELAY_W-1:0]    req_delay_ms,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [potb_pkg::MASK_W-1:0]     rsp_fired_mask,
   output logic [potb_pkg::MASK_W-1:0]     rsp_pending_after
);

   potb_pkg::cmd_type    cmd;
   potb_pkg::status_type status;

   // sequencing
   potb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // slot state and response payload
   potb_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_op            (req_op),
      .req_opcode        (req_opcode),
      .req_delay_ms      (req_delay_ms),
      .rsp_fired_mask    (rsp_fired_mask),
      .rsp_pending_after (rsp_pending_after)
   );

endmodule

// ===== src/potb_checker.sv =====
// port level checks for the pending operation timer bank
// depends on potb_pkg; bound to pending_op_timer_bank below
module potb_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input logic [potb_pkg::OP_W-1:0]       req_op,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [potb_pkg::MASK_W-1:0]     rsp_fired_mask,
   input logic [potb_pkg::MASK_W-1:0]     rsp_pending_after
);

   // a stalled response stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   // a slot that fired is no longer pending
   a_fired_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_fired_mask & rsp_pending_after) == '0))
      else $error("fired slot still pending");

   // one request at a time: the cycle after an accept is stalled
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while busy");

   // a fresh response comes from a tick accepted before the exec state that loads it
   a_rsp_from_tick: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> ($past(req_valid, 2) && !$past(req_stall, 2) &&
                            $past(req_op, 2) == potb_pkg::OP_TICK))
      else $error("response without a tick request");

   // reset leaves no response offered
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind pending_op_timer_bank potb_checker u_potb_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .req_op            (req_op),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_fired_mask    (rsp_fired_mask),
   .rsp_pending_after (rsp_pending_after)
);

// ===== bench/tb.sv =====
// testbench for the pending operation timer bank: directed and random requests
// checked against an in-bench prediction of the slot counters and pending mask
// depends on potb_pkg and pending_op_timer_bank
`timescale 1ns / 100ps

module tb;

   // op code with no function in the block
   localparam logic [potb_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
   // cycles without any handshake before the run is abandoned
   localparam int IDLE_LIMIT = 2000;
   // cycles allowed after the last response for stray output
   localparam int TAIL_CYCLES = 10;

   typedef struct packed {
      logic [potb_pkg::MASK_W-1:0] fired;
      logic [potb_pkg::MASK_W-1:0] pending;
   } tick_result_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   logic [potb_pkg::OP_W-1:0]       req_op = potb_pkg::OP_TICK;
   logic [potb_pkg::MASK_W-1:0]     req_opcode = '0;
   logic [potb_pkg::DELAY_W-1:0]    req_delay_ms = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   logic [potb_pkg::MASK_W-1:0]     rsp_fired_mask;
   logic [potb_pkg::MASK_W-1:0]     rsp_pending_after;

   // predicted block state
   logic [potb_pkg::MASK_W-1:0]     timer_pending;
   logic [potb_pkg::DELAY_W-1:0]    timer_count [potb_pkg::SLOTS];
   tick_result_type                 tick_results_q [$];

   int  error_count = 0;
   int  idle_cycles = 0;
   int  stall_hold = 0;
   bit  quiet = 1'b0;

   pending_op_timer_bank i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_op            (req_op),
      .req_opcode        (req_opcode),
      .req_delay_ms      (req_delay_ms),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_fired_mask    (rsp_fired_mask),
      .rsp_pending_after (rsp_pending_after)
   );

   // clock, 10 ns period
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // slot addressed by a multi-bit opcode: its highest set bit
   function automatic int highest_slot(input logic [potb_pkg::MASK_W-1:0] code);
      int pos;
      pos = 0;
      for (int i = 0; i < potb_pkg::SLOTS; i++) begin
         if (code[i]) begin
            pos = i;
         end
      end
      return pos;
   endfunction

   // advance the predicted state by one request; returns 1 when a tick response is due
   function automatic bit predict_timer_update(input logic [potb_pkg::OP_W-1:0] op,
                                               input logic [potb_pkg::MASK_W-1:0] code,
                                               input logic [potb_pkg::DELAY_W-1:0] delay,
                                               output tick_result_type res);
      logic [potb_pkg::MASK_W-1:0] fired;
      bit                          has_result;
      fired = '0;
      has_result = 1'b0;
      res = '0;
      case (op)
         potb_pkg::OP_ADD: begin
            // overlap with anything pending drops the whole add
            if (code != '0 && (timer_pending & code) == '0) begin
               timer_pending = timer_pending | code;
               timer_count[highest_slot(code)] = delay;
            end
         end
         potb_pkg::OP_CANCEL: begin
            if (code != '0) begin
               timer_count[highest_slot(code)] = '0;
               timer_pending = timer_pending & ~code;
            end
         end
         potb_pkg::OP_TICK: begin
            // every running counter steps down; reaching zero fires the slot
            for (int i = 0; i < potb_pkg::SLOTS; i++) begin
               if (timer_count[i] != '0) begin
                  timer_count[i] = timer_count[i] - 1'b1;
                  if (timer_count[i] == '0) begin
                     timer_pending[i] = 1'b0;
                     fired[i] = 1'b1;
                  end
               end
            end
            res.fired = fired;
            res.pending = timer_pending;
            has_result = 1'b1;
         end
         default: begin
         end
      endcase
      return has_result;
   endfunction

   // idle stretch length: mostly short, a few long
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 2);
      if (r < 95) return $urandom_range(3, 6);
      return $urandom_range(10, 40);
   endfunction

   function automatic int sender_gap();
      if (quiet || $urandom_range(0, 99) < 55) return 0;
      return idle_length();
   endfunction

   // receiver stall pattern
   always @(posedge clock) begin
      bit stalled;
      if (stall_hold > 0) begin
         stall_hold <= stall_hold - 1;
      end else begin
         stalled = !quiet && ($urandom_range(0, 99) < 25);
         rsp_stall <= stalled;
         stall_hold <= stalled ? idle_length() - 1 : $urandom_range(0, 6);
      end
   end

   // response check against the oldest predicted tick result
   always @(posedge clock) begin
      tick_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (tick_results_q.size() == 0) begin
            $error("unexpected response: fired_mask %h pending_after %h",
                   rsp_fired_mask, rsp_pending_after);
            error_count++;
         end else begin
            want = tick_results_q.pop_front();
            if (rsp_fired_mask !== want.fired) begin
               $error("fired_mask mismatch: expected %h, actual %h",
                      want.fired, rsp_fired_mask);
               error_count++;
            end
            if (rsp_pending_after !== want.pending) begin
               $error("pending_after mismatch: expected %h, actual %h",
                      want.pending, rsp_pending_after);
               error_count++;
            end
         end
      end
   end

   // watchdog on cycles with no handshake on either channel
   always @(posedge clock) begin
      if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // drive one request and hold it until accepted
   task automatic send_request(input logic [potb_pkg::OP_W-1:0] op,
                               input logic [potb_pkg::MASK_W-1:0] code,
                               input logic [potb_pkg::DELAY_W-1:0] delay);
      tick_result_type res;
      int              gap;
      req_valid <= 1'b1;
      req_op <= op;
      req_opcode <= code;
      req_delay_ms <= delay;
      do @(posedge clock); while (req_stall !== 1'b0);
      if (predict_timer_update(op, code, delay, res)) begin
         tick_results_q.push_back(res);
      end
      gap = sender_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // stop sending until every predicted response has come back
   task automatic wait_for_drain();
      if (tick_results_q.size() != 0) begin
         req_valid <= 1'b0;
         while (tick_results_q.size() != 0) @(posedge clock);
      end
   endtask

   // extremes, overlap, multi-bit opcodes, zero delay, unused op
   task automatic test_directed();
      send_request(potb_pkg::OP_TICK, 8'h00, 16'h0000);
      send_request(potb_pkg::OP_ADD, 8'h00, 16'h0005);
      send_request(potb_pkg::OP_CANCEL, 8'h00, 16'hFFFF);
      send_request(potb_pkg::OP_ADD, 8'h01, 16'h0001);
      send_request(potb_pkg::OP_TICK, 8'hFF, 16'hFFFF);
      send_request(potb_pkg::OP_ADD, 8'h80, 16'hFFFF);
      send_request(potb_pkg::OP_ADD, 8'h80, 16'h0002);
      send_request(potb_pkg::OP_ADD, 8'h06, 16'h0002);
      send_request(potb_pkg::OP_TICK, 8'h00, 16'h0000);
      send_request(potb_pkg::OP_TICK, 8'h00, 16'h0000);
      send_request(potb_pkg::OP_ADD, 8'h02, 16'h0003);
      send_request(potb_pkg::OP_ADD, 8'h10, 16'h0000);
      send_request(potb_pkg::OP_TICK, 8'h00, 16'h0000);
      send_request(OP_UNUSED, 8'hFF, 16'hFFFF);
      send_request(potb_pkg::OP_CANCEL, 8'h12, 16'h0000);
      send_request(potb_pkg::OP_CANCEL, 8'h80, 16'h0000);
      send_request(potb_pkg::OP_TICK, 8'h00, 16'h0000);
      send_request(potb_pkg::OP_ADD, 8'hFF, 16'h0003);
      send_request(potb_pkg::OP_TICK, 8'h00, 16'h0000);
      send_request(potb_pkg::OP_TICK, 8'h00, 16'h0000);
      send_request(potb_pkg::OP_TICK, 8'h00, 16'h0000);
      send_request(potb_pkg::OP_CANCEL, 8'hFF, 16'h0000);
      send_request(potb_pkg::OP_TICK, 8'h00, 16'h0000);
   endtask

   // mostly one-hot opcodes and short delays so slots fire often
   task automatic test_random_traffic(input int count, input bit no_idle);
      logic [potb_pkg::OP_W-1:0]    op;
      logic [potb_pkg::MASK_W-1:0]  code;
      logic [potb_pkg::DELAY_W-1:0] delay;
      int                           r;
      quiet = no_idle;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         if (r < 35) op = potb_pkg::OP_ADD;
         else if (r < 50) op = potb_pkg::OP_CANCEL;
         else if (r < 95) op = potb_pkg::OP_TICK;
         else op = OP_UNUSED;
         r = $urandom_range(0, 99);
         if (r < 75) code = 8'h01 << $urandom_range(0, 7);
         else if (r < 85) code = potb_pkg::MASK_W'($urandom_range(0, 255));
         else if (r < 90) code = 8'h00;
         else if (r < 95) code = 8'hFF;
         else code = (8'h01 << $urandom_range(0, 7)) | (8'h01 << $urandom_range(0, 7));
         r = $urandom_range(0, 99);
         if (r < 15) delay = 16'h0000;
         else if (r < 75) delay = potb_pkg::DELAY_W'($urandom_range(1, 6));
         else if (r < 93) delay = potb_pkg::DELAY_W'($urandom_range(7, 40));
         else delay = potb_pkg::DELAY_W'($urandom_range(0, 65535));
         send_request(op, code, delay);
      end
      quiet = 1'b0;
   endtask

   // sender holds off mid-stream until all responses are back
   task automatic test_drain_pause();
      send_request(potb_pkg::OP_ADD, 8'h04, 16'h0002);
      send_request(potb_pkg::OP_TICK, 8'h00, 16'h0000);
      send_request(potb_pkg::OP_TICK, 8'h00, 16'h0000);
      wait_for_drain();
      send_request(potb_pkg::OP_TICK, 8'h00, 16'h0000);
      test_random_traffic(100, 1'b0);
      wait_for_drain();
   endtask

   // test sequence
   initial begin
      timer_pending = '0;
      for (int i = 0; i < potb_pkg::SLOTS; i++) begin
         timer_count[i] = '0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_traffic(250, 1'b1);
      test_random_traffic(550, 1'b0);
      test_drain_pause();
      test_random_traffic(500, 1'b0);
      wait_for_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/potb_pkg.sv
src/potb_ctrl.sv
src/potb_dp.sv
src/pending_op_timer_bank.sv
src/potb_checker.sv
bench/tb.sv
